// File: hdl/pngm_pkg.sv
// shared types, constants and helper functions of the 1-bit grayscale PNG encoder
`timescale 1ns / 1ps
package pngm_pkg;

   // field and register widths
   localparam int WIDTH_W   = 14;
   localparam int HEIGHT_W  = 11;
   localparam int STRIDE_W  = 12;
   localparam int COL_W     = 11;
   localparam int RAW_W     = STRIDE_W + HEIGHT_W;
   localparam int LEN_W     = RAW_W + 1;
   localparam int STEP_W    = 6;
   localparam int CSR_IDX_W = 1;

   // largest IDAT chunk data length accepted
   localparam int MAX_IDAT_BYTES = 2048;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 1'b1;

   // request opcodes
   localparam logic OP_START = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   // stream constants
   localparam logic [63:0] PNG_SIG          = 64'h89504E470D0A1A0A;
   localparam logic [31:0] IHDR_LEN         = 32'd13;
   localparam logic [31:0] IHDR_TYPE        = 32'h49484452;
   localparam logic [31:0] IDAT_TYPE        = 32'h49444154;
   localparam logic [31:0] IEND_TYPE        = 32'h49454E44;
   localparam logic [31:0] IEND_CRC         = 32'hAE426082;
   localparam logic [7:0]  ZLIB_CMF         = 8'h78;
   localparam logic [7:0]  ZLIB_FLG         = 8'h01;
   localparam logic [7:0]  BLK_FINAL_STORED = 8'h01;
   localparam logic [7:0]  FILTER_NONE      = 8'h00;
   localparam logic [7:0]  BIT_DEPTH_ONE    = 8'h01;
   localparam logic [31:0] CRC_POLY         = 32'hEDB88320;
   localparam logic [16:0] ADLER_MOD        = 17'd65521;
   localparam logic [LEN_W-1:0] IDAT_EXTRA_BYTES = LEN_W'(11);

   // byte positions of the start sequence (counted from its first word)
   localparam logic [STEP_W-1:0] S_IHDR_LEN  = 6'd8;
   localparam logic [STEP_W-1:0] S_IHDR_TYPE = 6'd12;
   localparam logic [STEP_W-1:0] S_IHDR_DATA = 6'd16;
   localparam logic [STEP_W-1:0] S_IHDR_CRC  = 6'd29;
   localparam logic [STEP_W-1:0] S_IDAT_LEN  = 6'd33;
   localparam logic [STEP_W-1:0] S_IDAT_TYPE = 6'd37;
   localparam logic [STEP_W-1:0] S_ZHDR      = 6'd41;
   localparam logic [STEP_W-1:0] S_BLK       = 6'd43;
   localparam logic [STEP_W-1:0] S_FILTER    = 6'd48;

   // IHDR data byte positions holding variable or nonzero values
   localparam logic [STEP_W-1:0] H_WIDTH_HI  = 6'd2;
   localparam logic [STEP_W-1:0] H_WIDTH_LO  = 6'd3;
   localparam logic [STEP_W-1:0] H_HEIGHT_HI = 6'd6;
   localparam logic [STEP_W-1:0] H_HEIGHT_LO = 6'd7;
   localparam logic [STEP_W-1:0] H_DEPTH     = 6'd8;

   // stored block header positions
   localparam logic [STEP_W-1:0] B_FLAGS   = 6'd0;
   localparam logic [STEP_W-1:0] B_LEN_LO  = 6'd1;
   localparam logic [STEP_W-1:0] B_LEN_HI  = 6'd2;
   localparam logic [STEP_W-1:0] B_NLEN_LO = 6'd3;

   // trailer step positions of the last pixel word
   localparam logic [STEP_W-1:0] T_ADLER     = 6'd1;
   localparam logic [STEP_W-1:0] T_CRC       = 6'd5;
   localparam logic [STEP_W-1:0] T_IEND_LEN  = 6'd9;
   localparam logic [STEP_W-1:0] T_IEND_TYPE = 6'd13;
   localparam logic [STEP_W-1:0] T_IEND_CRC  = 6'd17;
   localparam logic [STEP_W-1:0] T_LAST      = 6'd20;

   typedef logic [7:0] octet_type;

   // commands to the checksum unit
   typedef struct packed {
      logic      hdr_init;
      logic      hdr_feed;
      logic      idat_init;
      logic      idat_feed;
      logic      adler_init;
      logic      adler_feed;
      octet_type data;
   } cksum_cmd_type;

   // image size information from the register block
   typedef struct packed {
      logic [WIDTH_W-1:0]  width;
      logic [HEIGHT_W-1:0] height;
      logic [STRIDE_W-1:0] stride;
      logic [15:0]         raw;
      logic [LEN_W-1:0]    chunk_len;
      logic                size_err;
   } size_info_type;

   // one result word
   typedef struct packed {
      octet_type out_byte;
      logic      last_byte;
      logic      size_error;
   } word_type;

   // big-endian byte k of a 32-bit value
   function automatic octet_type be_byte(input logic [31:0] v, input logic [1:0] k);
      octet_type r;
      case (k)
         2'd0: r = v[31:24];
         2'd1: r = v[23:16];
         2'd2: r = v[15:8];
         default: r = v[7:0];
      endcase
      return r;
   endfunction

   // one byte of the reflected CRC-32
   function automatic logic [31:0] crc_byte(input logic [31:0] c, input octet_type b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
      end
      return r;
   endfunction

endpackage

// File: hdl/png_mono_stored_encoder.sv
// top level: request sequencer of the 1-bit grayscale PNG encoder
// Throughput: one result word per cycle while rsp_stall is low; a request holds the
// sequencer until its final word is taken (a start begins with a setup step that
// gives no word, a pixel at a row end adds a filter byte, the last pixel adds the
// trailer), limited by the single byte output register.
// A word passes the request register and then the byte output register.
// The next request is accepted in the cycle its predecessor's final word is issued.
// Reset (synchronous): no image open, output empty, registers 128 x 32; no clear pass.
`timescale 1ns / 1ps
module png_mono_stored_encoder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_op,
   input  logic [7:0]                       req_pixel_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_out_byte,
   output logic                             rsp_last_byte,
   output logic                             rsp_size_error,
   input  logic                             csr_write_en,
   input  logic [pngm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pngm_pkg::WIDTH_W-1:0]     csr_data
);
   import pngm_pkg::*;

   size_info_type size_info;
   cksum_cmd_type cmd;
   cksum_cmd_type cmd_go;
   word_type      emit_word;
   logic          emit_valid;
   logic          emit_ready;
   logic [31:0]   hdr_crc;
   logic [31:0]   idat_crc;
   logic [15:0]   adler_low;
   logic [15:0]   adler_high;

   logic                busy_ff;
   logic                op_ff;
   octet_type           pix_ff;
   logic [STEP_W-1:0]   step_ff;
   logic                active_ff;
   logic [COL_W-1:0]    col_ff;
   logic [HEIGHT_W-1:0] row_ff;
   logic [STRIDE_W-1:0] stride_ff;
   logic [HEIGHT_W-1:0] rows_ff;
   logic                final_ff;

   logic                accept;
   logic                can_go;
   logic                last_step;
   logic [STEP_W-1:0]   idx;
   logic [STEP_W-1:0]   kk;
   logic [STRIDE_W-1:0] col_next;
   logic [HEIGHT_W:0]   row_next;
   logic                row_end;
   logic                img_end;
   logic [31:0]         ihdr_crc_out;
   logic [31:0]         idat_crc_out;
   logic [31:0]         chunk_len32;
   logic [31:0]         adler32;

   pngm_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .size_info    (size_info)
   );

   pngm_cksum u_cksum (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd_go),
      .hdr_crc    (hdr_crc),
      .idat_crc   (idat_crc),
      .adler_low  (adler_low),
      .adler_high (adler_high)
   );

   // only a request in progress offers words
   pngm_outbuf u_outbuf (
      .clock          (clock),
      .reset          (reset),
      .emit_valid     (busy_ff && emit_valid),
      .emit_word      (emit_word),
      .emit_ready     (emit_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last_byte  (rsp_last_byte),
      .rsp_size_error (rsp_size_error)
   );

   // row and image end detection for the pixel being passed
   assign col_next     = {1'b0, col_ff} + STRIDE_W'(1);
   assign row_next     = {1'b0, row_ff} + (HEIGHT_W+1)'(1);
   assign row_end      = col_next >= stride_ff;
   assign img_end      = row_end && (row_next >= {1'b0, rows_ff});
   assign ihdr_crc_out = ~hdr_crc;
   assign idat_crc_out = ~idat_crc;
   assign chunk_len32  = 32'(size_info.chunk_len);
   assign adler32      = {adler_high, adler_low};
   assign idx          = step_ff - STEP_W'(1);

   // word and checksum command for the current step
   always_comb begin
      emit_valid = 1'b0;
      emit_word  = '0;
      cmd        = '0;
      last_step  = 1'b0;
      kk         = '0;
      case (op_ff)
         OP_START: begin
            if (step_ff == '0) begin
               last_step = 1'b0;
            end else if (step_ff == STEP_W'(1) && size_info.size_err) begin
               emit_valid           = 1'b1;
               emit_word.last_byte  = 1'b1;
               emit_word.size_error = 1'b1;
               last_step            = 1'b1;
            end else begin
               emit_valid = 1'b1;
               if (step_ff == STEP_W'(1)) begin
                  cmd.hdr_init   = 1'b1;
                  cmd.idat_init  = 1'b1;
                  cmd.adler_init = 1'b1;
               end
               if (idx < S_IHDR_LEN) begin
                  emit_word.out_byte = 8'(PNG_SIG >> (6'd56 - {idx[2:0], 3'b000}));
               end else if (idx < S_IHDR_TYPE) begin
                  kk = idx - S_IHDR_LEN;
                  emit_word.out_byte = be_byte(IHDR_LEN, kk[1:0]);
               end else if (idx < S_IHDR_DATA) begin
                  kk = idx - S_IHDR_TYPE;
                  emit_word.out_byte = be_byte(IHDR_TYPE, kk[1:0]);
                  cmd.hdr_feed = 1'b1;
               end else if (idx < S_IHDR_CRC) begin
                  kk = idx - S_IHDR_DATA;
                  case (kk)
                     H_WIDTH_HI:  emit_word.out_byte = {2'b00, size_info.width[13:8]};
                     H_WIDTH_LO:  emit_word.out_byte = size_info.width[7:0];
                     H_HEIGHT_HI: emit_word.out_byte = {5'd0, size_info.height[10:8]};
                     H_HEIGHT_LO: emit_word.out_byte = size_info.height[7:0];
                     H_DEPTH:     emit_word.out_byte = BIT_DEPTH_ONE;
                     default:     emit_word.out_byte = '0;
                  endcase
                  cmd.hdr_feed = 1'b1;
               end else if (idx < S_IDAT_LEN) begin
                  kk = idx - S_IHDR_CRC;
                  emit_word.out_byte = be_byte(ihdr_crc_out, kk[1:0]);
               end else if (idx < S_IDAT_TYPE) begin
                  kk = idx - S_IDAT_LEN;
                  emit_word.out_byte = be_byte(chunk_len32, kk[1:0]);
               end else if (idx < S_ZHDR) begin
                  kk = idx - S_IDAT_TYPE;
                  emit_word.out_byte = be_byte(IDAT_TYPE, kk[1:0]);
                  cmd.idat_feed = 1'b1;
               end else if (idx < S_BLK) begin
                  emit_word.out_byte = (idx == S_ZHDR) ? ZLIB_CMF : ZLIB_FLG;
                  cmd.idat_feed = 1'b1;
               end else if (idx < S_FILTER) begin
                  kk = idx - S_BLK;
                  case (kk)
                     B_FLAGS:   emit_word.out_byte = BLK_FINAL_STORED;
                     B_LEN_LO:  emit_word.out_byte = size_info.raw[7:0];
                     B_LEN_HI:  emit_word.out_byte = size_info.raw[15:8];
                     B_NLEN_LO: emit_word.out_byte = ~size_info.raw[7:0];
                     default:   emit_word.out_byte = ~size_info.raw[15:8];
                  endcase
                  cmd.idat_feed = 1'b1;
               end else begin
                  emit_word.out_byte = FILTER_NONE;
                  cmd.idat_feed  = 1'b1;
                  cmd.adler_feed = 1'b1;
                  last_step      = 1'b1;
               end
            end
         end
         OP_PIXEL: begin
            if (step_ff == '0) begin
               if (!active_ff) begin
                  last_step = 1'b1;
               end else begin
                  emit_valid         = 1'b1;
                  emit_word.out_byte = pix_ff;
                  cmd.idat_feed      = 1'b1;
                  cmd.adler_feed     = 1'b1;
                  last_step          = !row_end;
               end
            end else if (!final_ff) begin
               emit_valid         = 1'b1;
               emit_word.out_byte = FILTER_NONE;
               cmd.idat_feed      = 1'b1;
               cmd.adler_feed     = 1'b1;
               last_step          = 1'b1;
            end else begin
               emit_valid = 1'b1;
               if (step_ff < T_CRC) begin
                  kk = step_ff - T_ADLER;
                  emit_word.out_byte = be_byte(adler32, kk[1:0]);
                  cmd.idat_feed = 1'b1;
               end else if (step_ff < T_IEND_LEN) begin
                  kk = step_ff - T_CRC;
                  emit_word.out_byte = be_byte(idat_crc_out, kk[1:0]);
               end else if (step_ff < T_IEND_TYPE) begin
                  emit_word.out_byte = '0;
               end else if (step_ff < T_IEND_CRC) begin
                  kk = step_ff - T_IEND_TYPE;
                  emit_word.out_byte = be_byte(IEND_TYPE, kk[1:0]);
               end else begin
                  kk = step_ff - T_IEND_CRC;
                  emit_word.out_byte  = be_byte(IEND_CRC, kk[1:0]);
                  emit_word.last_byte = (step_ff == T_LAST);
                  last_step           = (step_ff == T_LAST);
               end
            end
         end
         default: last_step = 1'b1;
      endcase
      cmd.data = emit_word.out_byte;
   end

   // a step proceeds when it has no word or the output register takes it
   assign can_go    = busy_ff && (!emit_valid || emit_ready);
   assign cmd_go    = can_go ? cmd : '0;
   assign req_stall = busy_ff && !(can_go && last_step);
   assign accept    = req_valid && !req_stall;

   // request register and step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (accept) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (can_go) begin
         if (last_step) begin
            busy_ff <= 1'b0;
         end else begin
            step_ff <= step_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_op;
         pix_ff <= req_pixel_byte;
      end
   end

   // image position and open flag
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         col_ff    <= '0;
         row_ff    <= '0;
         final_ff  <= 1'b0;
      end else if (can_go) begin
         if (op_ff == OP_START) begin
            if (step_ff == STEP_W'(1)) begin
               col_ff    <= '0;
               row_ff    <= '0;
               active_ff <= 1'b0;
            end
            if (last_step && !size_info.size_err) begin
               active_ff <= 1'b1;
            end
         end else if (step_ff == '0 && active_ff) begin
            final_ff <= img_end;
            if (row_end) begin
               col_ff <= '0;
               row_ff <= row_next[HEIGHT_W-1:0];
               if (img_end) begin
                  active_ff <= 1'b0;
               end
            end else begin
               col_ff <= col_next[COL_W-1:0];
            end
         end
      end
   end

   // image geometry latched at start
   always_ff @(posedge clock) begin
      if (can_go && op_ff == OP_START && step_ff == STEP_W'(1)) begin
         stride_ff <= size_info.stride;
         rows_ff   <= size_info.height;
      end
   end

endmodule

// File: hdl/pngm_csr.sv
// configuration registers and image size check
`timescale 1ns / 1ps
module pngm_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [pngm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pngm_pkg::WIDTH_W-1:0]     csr_data,
   output pngm_pkg::size_info_type          size_info
);
   import pngm_pkg::*;

   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [RAW_W-1:0]    raw_ff;
   logic [RAW_W-1:0]    raw_in;
   logic [STRIDE_W-1:0] stride;
   logic [LEN_W-1:0]    chunk_len;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_W'(128);
         height_ff <= HEIGHT_W'(32);
      end else if (csr_write_en) begin
         case (csr_index)
            REG_WIDTH:  width_ff  <= csr_data;
            REG_HEIGHT: height_ff <= csr_data[HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // row stride in bytes and raw scanline data size
   assign stride = STRIDE_W'(({1'b0, width_ff} + (WIDTH_W+1)'(7)) >> 3);
   assign raw_in = (RAW_W'(stride) + RAW_W'(1)) * RAW_W'(height_ff);

   always_ff @(posedge clock) begin
      raw_ff <= raw_in;
   end

   assign chunk_len = {1'b0, raw_ff} + IDAT_EXTRA_BYTES;

   always_comb begin
      size_info.width     = width_ff;
      size_info.height    = height_ff;
      size_info.stride    = stride;
      size_info.raw       = raw_ff[15:0];
      size_info.chunk_len = chunk_len;
      size_info.size_err  = (width_ff == '0) || (height_ff == '0) ||
                            (chunk_len > LEN_W'(MAX_IDAT_BYTES));
   end

endmodule

// File: hdl/pngm_cksum.sv
// CRC-32 and Adler-32 accumulators
`timescale 1ns / 1ps
module pngm_cksum (
   input  logic                     clock,
   input  logic                     reset,
   input  pngm_pkg::cksum_cmd_type  cmd,
   output logic [31:0]              hdr_crc,
   output logic [31:0]              idat_crc,
   output logic [15:0]              adler_low,
   output logic [15:0]              adler_high
);
   import pngm_pkg::*;

   logic [31:0] hdr_crc_ff;
   logic [31:0] idat_crc_ff;
   logic [15:0] low_ff;
   logic [15:0] high_ff;
   logic [16:0] low_sum;
   logic [15:0] low_in;
   logic [16:0] high_sum;
   logic [15:0] high_in;

   // adler sums with one conditional subtract each
   always_comb begin
      low_sum  = {1'b0, low_ff} + {9'd0, cmd.data};
      low_in   = (low_sum >= ADLER_MOD) ? 16'(low_sum - ADLER_MOD) : low_sum[15:0];
      high_sum = {1'b0, high_ff} + {1'b0, low_in};
      high_in  = (high_sum >= ADLER_MOD) ? 16'(high_sum - ADLER_MOD) : high_sum[15:0];
   end

   // header crc, running idat crc and adler sums
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_crc_ff  <= '1;
         idat_crc_ff <= '1;
         low_ff      <= 16'd1;
         high_ff     <= '0;
      end else begin
         if (cmd.hdr_init) begin
            hdr_crc_ff <= '1;
         end else if (cmd.hdr_feed) begin
            hdr_crc_ff <= crc_byte(hdr_crc_ff, cmd.data);
         end
         if (cmd.idat_init) begin
            idat_crc_ff <= '1;
         end else if (cmd.idat_feed) begin
            idat_crc_ff <= crc_byte(idat_crc_ff, cmd.data);
         end
         if (cmd.adler_init) begin
            low_ff  <= 16'd1;
            high_ff <= '0;
         end else if (cmd.adler_feed) begin
            low_ff  <= low_in;
            high_ff <= high_in;
         end
      end
   end

   assign hdr_crc    = hdr_crc_ff;
   assign idat_crc   = idat_crc_ff;
   assign adler_low  = low_ff;
   assign adler_high = high_ff;

endmodule

// File: hdl/pngm_outbuf.sv
// result output register
`timescale 1ns / 1ps
module pngm_outbuf (
   input  logic                clock,
   input  logic                reset,
   input  logic                emit_valid,
   input  pngm_pkg::word_type  emit_word,
   output logic                emit_ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_last_byte,
   output logic                rsp_size_error
);
   import pngm_pkg::*;

   logic     valid_ff;
   word_type word_ff;

   // free when empty or when the held word leaves this cycle
   assign emit_ready = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (emit_ready) begin
         valid_ff <= emit_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_ready && emit_valid) begin
         word_ff <= emit_word;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = word_ff.out_byte;
   assign rsp_last_byte  = word_ff.last_byte;
   assign rsp_size_error = word_ff.size_error;

endmodule

// File: sim/tb_png_mono_stored_encoder.sv
// self-checking testbench of the 1-bit grayscale PNG stream encoder
`timescale 1ns / 1ps
module tb_png_mono_stored_encoder;
   import pngm_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int RAND_ITEMS  = 150;
   localparam int IDLE_PCT    = 16;
   localparam int SETTLE_CYC  = 4;
   localparam int TAIL_CYC    = 40;
   localparam int SHOW_MAX    = 10;
   localparam int DIR_ROWS    = 39;

   typedef enum logic [1:0] {ROW_SET_WIDTH, ROW_SET_HEIGHT, ROW_START, ROW_PIXEL} row_kind_type;
   typedef enum logic [1:0] {CHK_ENCODE, CHK_SIZE_ERR, CHK_SILENT} row_check_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [WIDTH_W-1:0] data;
      row_check_type      chk;
   } plan_row_type;

   // directed plan: register writes and requests, typed checks where obvious
   plan_row_type dir_plan [DIR_ROWS] = '{
      '{ROW_PIXEL,      14'h00FF, CHK_SILENT},
      '{ROW_START,      14'h0000, CHK_ENCODE},
      '{ROW_PIXEL,      14'h00A5, CHK_ENCODE},
      '{ROW_SET_WIDTH,  14'd0,    CHK_ENCODE},
      '{ROW_START,      14'h0000, CHK_SIZE_ERR},
      '{ROW_PIXEL,      14'h0055, CHK_SILENT},
      '{ROW_SET_WIDTH,  14'd1,    CHK_ENCODE},
      '{ROW_SET_HEIGHT, 14'd0,    CHK_ENCODE},
      '{ROW_START,      14'h0000, CHK_SIZE_ERR},
      '{ROW_SET_WIDTH,  14'h3FFF, CHK_ENCODE},
      '{ROW_SET_HEIGHT, 14'd1,    CHK_ENCODE},
      '{ROW_START,      14'h0000, CHK_SIZE_ERR},
      '{ROW_SET_WIDTH,  14'd16289, CHK_ENCODE},
      '{ROW_START,      14'h0000, CHK_SIZE_ERR},
      '{ROW_SET_WIDTH,  14'd16288, CHK_ENCODE},
      '{ROW_START,      14'h0000, CHK_ENCODE},
      '{ROW_PIXEL,      14'h00FF, CHK_ENCODE},
      '{ROW_SET_WIDTH,  14'd1,    CHK_ENCODE},
      '{ROW_SET_HEIGHT, 14'd1019, CHK_ENCODE},
      '{ROW_START,      14'h0000, CHK_SIZE_ERR},
      '{ROW_SET_HEIGHT, 14'd1018, CHK_ENCODE},
      '{ROW_START,      14'h0000, CHK_ENCODE},
      '{ROW_SET_WIDTH,  14'd8,    CHK_ENCODE},
      '{ROW_SET_HEIGHT, 14'd1,    CHK_ENCODE},
      '{ROW_START,      14'h0000, CHK_ENCODE},
      '{ROW_PIXEL,      14'h0000, CHK_ENCODE},
      '{ROW_PIXEL,      14'h00FF, CHK_SILENT},
      '{ROW_SET_WIDTH,  14'd1,    CHK_ENCODE},
      '{ROW_SET_HEIGHT, 14'd2,    CHK_ENCODE},
      '{ROW_START,      14'h0000, CHK_ENCODE},
      '{ROW_PIXEL,      14'h0080, CHK_ENCODE},
      '{ROW_PIXEL,      14'h007F, CHK_ENCODE},
      '{ROW_SET_HEIGHT, 14'h3FFF, CHK_ENCODE},
      '{ROW_START,      14'h0000, CHK_SIZE_ERR},
      '{ROW_SET_WIDTH,  14'd9,    CHK_ENCODE},
      '{ROW_SET_HEIGHT, 14'd1,    CHK_ENCODE},
      '{ROW_START,      14'h0000, CHK_ENCODE},
      '{ROW_PIXEL,      14'h00FF, CHK_ENCODE},
      '{ROW_PIXEL,      14'h0080, CHK_ENCODE}
   };

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_stall;
   logic                 req_op         = OP_START;
   logic [7:0]           req_pixel_byte = 8'h00;
   logic                 rsp_valid;
   logic                 rsp_stall      = 1'b0;
   logic [7:0]           rsp_out_byte;
   logic                 rsp_last_byte;
   logic                 rsp_size_error;
   logic                 csr_write_en   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index      = REG_WIDTH;
   logic [WIDTH_W-1:0]   csr_data       = '0;

   // predicted encoder state
   logic [WIDTH_W-1:0]  set_width  = 14'd128;
   logic [HEIGHT_W-1:0] set_height = 11'd32;
   bit                  img_open   = 1'b0;
   logic [31:0]         idat_crc   = 32'hFFFF_FFFF;
   logic [16:0]         sum_a      = 17'd1;
   logic [16:0]         sum_b      = 17'd0;
   int                  col_idx    = 0;
   int                  row_idx    = 0;
   int                  img_stride = 0;
   int                  img_rows   = 0;

   word_type encoded[$];
   word_type words_due[$];
   int       err_count   = 0;
   int       cycle_count = 0;
   int       items_done  = 0;
   bit       send_idle   = 1'b1;
   logic     recv_idle   = 1'b1;

   png_mono_stored_encoder u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_pixel_byte (req_pixel_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last_byte  (rsp_last_byte),
      .rsp_size_error (rsp_size_error),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void flag_error(input string msg);
      err_count++;
      if (err_count <= SHOW_MAX) $display("[%0t] %s", $time, msg);
   endfunction

   // reflected crc-32, one byte at a time
   function automatic logic [31:0] crc32_add(input logic [31:0] c, input octet_type b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
   endfunction

   function automatic void put_word(input octet_type b, input logic last, input logic err);
      word_type w;
      w.out_byte   = b;
      w.last_byte  = last;
      w.size_error = err;
      encoded.push_back(w);
   endfunction

   // byte inside the IDAT type or data field
   function automatic void put_idat(input octet_type b);
      idat_crc = crc32_add(idat_crc, b);
      put_word(b, 1'b0, 1'b0);
   endfunction

   function automatic void put_be32(input logic [31:0] v);
      for (int k = 3; k >= 0; k--) put_word(v[8*k +: 8], 1'b0, 1'b0);
   endfunction

   // adler-32 sums with a single conditional subtract each
   function automatic void adler_add(input octet_type b);
      sum_a = sum_a + b;
      if (sum_a >= ADLER_MOD) sum_a = sum_a - ADLER_MOD;
      sum_b = sum_b + sum_a;
      if (sum_b >= ADLER_MOD) sum_b = sum_b - ADLER_MOD;
   endfunction

   // start: size check, then headers up to the first filter byte
   function automatic void encode_start();
      int          stride;
      int          raw;
      int          chunk_len;
      octet_type   hdr [17];
      logic [31:0] hcrc;
      stride    = (int'(set_width) + 7) >> 3;
      raw       = (1 + stride) * int'(set_height);
      chunk_len = raw + 11;
      if (set_width == 0 || set_height == 0 || chunk_len > MAX_IDAT_BYTES) begin
         img_open = 1'b0;
         put_word(8'h00, 1'b1, 1'b1);
         return;
      end
      for (int k = 7; k >= 0; k--) put_word(PNG_SIG[8*k +: 8], 1'b0, 1'b0);
      put_be32(IHDR_LEN);
      // IHDR type and data share one crc
      for (int k = 0; k < 4; k++) hdr[k] = IHDR_TYPE[8*(3-k) +: 8];
      for (int k = 4; k < 17; k++) hdr[k] = 8'h00;
      hdr[6]  = {2'b00, set_width[13:8]};
      hdr[7]  = set_width[7:0];
      hdr[10] = {5'd0, set_height[10:8]};
      hdr[11] = set_height[7:0];
      hdr[12] = BIT_DEPTH_ONE;
      hcrc = 32'hFFFF_FFFF;
      for (int k = 0; k < 17; k++) begin
         hcrc = crc32_add(hcrc, hdr[k]);
         put_word(hdr[k], 1'b0, 1'b0);
      end
      put_be32(~hcrc);
      // IDAT length, type, zlib header and stored block header
      put_be32(32'(chunk_len));
      idat_crc = 32'hFFFF_FFFF;
      for (int k = 3; k >= 0; k--) put_idat(IDAT_TYPE[8*k +: 8]);
      put_idat(ZLIB_CMF);
      put_idat(ZLIB_FLG);
      put_idat(BLK_FINAL_STORED);
      put_idat(raw[7:0]);
      put_idat(raw[15:8]);
      put_idat(~raw[7:0]);
      put_idat(~raw[15:8]);
      sum_a = 17'd1;
      sum_b = 17'd0;
      put_idat(FILTER_NONE);
      adler_add(FILTER_NONE);
      col_idx    = 0;
      row_idx    = 0;
      img_stride = stride;
      img_rows   = int'(set_height);
      img_open   = 1'b1;
   endfunction

   // pixel byte: pass through, then a filter byte or the trailer at a row end
   function automatic void encode_pixel(input octet_type b);
      logic [31:0] adler;
      logic [31:0] c;
      if (!img_open) return;
      put_idat(b);
      adler_add(b);
      col_idx++;
      if (col_idx < img_stride) return;
      col_idx = 0;
      row_idx++;
      if (row_idx < img_rows) begin
         put_idat(FILTER_NONE);
         adler_add(FILTER_NONE);
         return;
      end
      adler = {sum_b[15:0], sum_a[15:0]};
      for (int k = 3; k >= 0; k--) put_idat(adler[8*k +: 8]);
      put_be32(~idat_crc);
      // IEND chunk
      put_be32(32'd0);
      c = 32'hFFFF_FFFF;
      for (int k = 3; k >= 0; k--) begin
         c = crc32_add(c, IEND_TYPE[8*k +: 8]);
         put_word(IEND_TYPE[8*k +: 8], 1'b0, 1'b0);
      end
      c = ~c;
      for (int k = 3; k >= 1; k--) put_word(c[8*k +: 8], 1'b0, 1'b0);
      put_word(c[7:0], 1'b1, 1'b0);
      img_open = 1'b0;
   endfunction

   // result side: random stall, each accepted word against the oldest one due
   always @(posedge clock) begin : rsp_check
      word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (words_due.size() == 0) begin
            flag_error($sformatf("unexpected word: byte %02h last %0b err %0b",
                                 rsp_out_byte, rsp_last_byte, rsp_size_error));
         end else begin
            want = words_due.pop_front();
            if (rsp_out_byte !== want.out_byte || rsp_last_byte !== want.last_byte ||
                rsp_size_error !== want.size_error) begin
               flag_error($sformatf("word mismatch: exp byte %02h last %0b err %0b, got %02h %0b %0b",
                                    want.out_byte, want.last_byte, want.size_error,
                                    rsp_out_byte, rsp_last_byte, rsp_size_error));
            end
         end
      end
      rsp_stall <= !reset && recv_idle && ($urandom_range(0, 99) < IDLE_PCT);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // present one request word and hold it until accepted
   task automatic push_request(input logic op, input octet_type pb);
      while (send_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_pixel_byte <= pb;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // send a request and queue the words it should produce
   task automatic issue(input logic op, input octet_type pb, input row_check_type chk);
      word_type w;
      push_request(op, pb);
      encoded.delete();
      if (op == OP_START) encode_start();
      else encode_pixel(pb);
      if (encoded.size() != 0) items_done++;
      case (chk)
         CHK_SIZE_ERR: begin
            w.out_byte   = 8'h00;
            w.last_byte  = 1'b1;
            w.size_error = 1'b1;
            words_due.push_back(w);
         end
         CHK_SILENT: begin
         end
         default: begin
            foreach (encoded[k]) words_due.push_back(encoded[k]);
         end
      endcase
   endtask

   // stop sending, wait for every due word, then let the block go quiet
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (words_due.size() != 0);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WIDTH_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      if (idx == REG_WIDTH) set_width = val;
      else set_height = val[HEIGHT_W-1:0];
   endtask

   initial begin : stimulus
      plan_row_type       row;
      bit                 after_req;
      bit                 first_cfg;
      int                 base;
      int                 shape;
      int                 total;
      int                 n_pix;
      logic [WIDTH_W-1:0] w_new;
      logic [WIDTH_W-1:0] h_new;
      octet_type          pb;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      after_req = 1'b0;
      for (int r = 0; r < DIR_ROWS; r++) begin
         row = dir_plan[r];
         case (row.kind)
            ROW_SET_WIDTH, ROW_SET_HEIGHT: begin
               if (after_req) settle();
               after_req = 1'b0;
               write_reg(row.kind == ROW_SET_WIDTH ? REG_WIDTH : REG_HEIGHT, row.data);
            end
            ROW_START: begin
               issue(OP_START, 8'h00, row.chk);
               after_req = 1'b1;
            end
            default: begin
               issue(OP_PIXEL, row.data[7:0], row.chk);
               after_req = 1'b1;
            end
         endcase
      end

      // one long image of mostly ones so both adler sums wrap
      settle();
      write_reg(REG_WIDTH, 14'd1200);
      write_reg(REG_HEIGHT, 14'd2);
      issue(OP_START, 8'h00, CHK_ENCODE);
      repeat (300) issue(OP_PIXEL, octet_type'($urandom_range(240, 255)), CHK_ENCODE);

      // random images: mostly complete small ones, some cut short, some noise
      base      = items_done;
      first_cfg = 1'b1;
      while (items_done - base < RAND_ITEMS) begin
         // quiet stretch in the middle with no idling on either side
         send_idle = !((items_done - base) >= 40 && (items_done - base) < 100);
         recv_idle <= send_idle;

         if (first_cfg || $urandom_range(0, 2) == 0) begin
            first_cfg = 1'b0;
            shape = $urandom_range(0, 99);
            if (shape < 70) begin
               w_new = WIDTH_W'($urandom_range(1, 48));
               h_new = WIDTH_W'($urandom_range(1, 4));
            end else if (shape < 78) begin
               w_new = $urandom_range(0, 1) ? '0 : WIDTH_W'($urandom_range(0, 16383));
               h_new = (w_new == 0) ? WIDTH_W'($urandom_range(0, 16383)) : '0;
            end else if (shape < 90) begin
               w_new = WIDTH_W'($urandom_range(0, 16383));
               h_new = WIDTH_W'($urandom_range(0, 16383));
            end else if (shape < 95) begin
               w_new = WIDTH_W'(16288 + $urandom_range(0, 1));
               h_new = 14'd1;
            end else begin
               w_new = WIDTH_W'($urandom_range(1, 8));
               h_new = WIDTH_W'(1018 + $urandom_range(0, 1));
            end
            settle();
            write_reg(REG_WIDTH, w_new);
            write_reg(REG_HEIGHT, h_new);
         end else if ($urandom_range(0, 9) == 0) begin
            settle();
         end

         shape = $urandom_range(0, 99);
         if (shape < 10) begin
            // noise words, ignored unless an image was left open
            repeat ($urandom_range(1, 3)) issue(OP_PIXEL, octet_type'($urandom), CHK_ENCODE);
         end else begin
            issue(OP_START, octet_type'($urandom), CHK_ENCODE);
            if (img_open) begin
               total = img_stride * img_rows;
               if (shape < 25 || total > 64)
                  n_pix = $urandom_range(0, (total > 12) ? 12 : total - 1);
               else
                  n_pix = total;
               repeat (n_pix) begin
                  case ($urandom_range(0, 7))
                     0: pb = 8'h00;
                     1: pb = 8'hFF;
                     default: pb = octet_type'($urandom);
                  endcase
                  issue(OP_PIXEL, pb, CHK_ENCODE);
               end
            end else begin
               repeat ($urandom_range(0, 2)) issue(OP_PIXEL, octet_type'($urandom), CHK_ENCODE);
            end
         end
      end

      // drain and finish
      send_idle = 1'b1;
      settle();
      repeat (TAIL_CYC) @(posedge clock);
      if (err_count == 0 && words_due.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
